>>> design/hcgs_pkg.sv
// ----------------------------------------------------------------------------
// hcgs_pkg
// Shared types and constants for the hill-climbing graph search block.
// ----------------------------------------------------------------------------
`default_nettype none

package hcgs_pkg;

    localparam int NODES   = 16;
    localparam int NODE_W  = $clog2(NODES);
    localparam int CNT_W   = NODE_W + 1;
    localparam int VAL_W   = 16;
    localparam int MAX_OUT = 16;

    // request commands
    typedef enum logic [1:0] {
        CMD_LOAD_ROW = 2'd0,
        CMD_LOAD_VAL = 2'd1,
        CMD_SEARCH   = 2'd2,
        CMD_NONE     = 2'd3
    } t_cmd;

    // result status codes
    typedef enum logic [1:0] {
        ST_PATH     = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_SAME     = 2'd2
    } t_status;

    // search sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_SCAN,
        S_INS,
        S_PUSH,
        S_RES,
        S_PATH
    } t_state;

    // one request as decoded by the top level
    typedef struct packed {
        t_cmd                    cmd;
        logic [NODE_W-1:0]       node_index;
        logic [NODES-1:0]        row_bits;
        logic signed [VAL_W-1:0] node_value;
        logic [NODE_W-1:0]       start_node;
        logic [NODE_W-1:0]       target_node;
    } t_req;

    // one result item
    typedef struct packed {
        t_status           status;
        logic [NODE_W-1:0] path_node;
        logic              last;
    } t_res;

endpackage

`default_nettype wire

>>> design/hcgs_core.sv
// ----------------------------------------------------------------------------
// hcgs_core
// Graph storage and the search sequencer: pop, successor scan with a
// one-step-per-cycle sorted insert, push, and parent-path walk.
// ----------------------------------------------------------------------------
`default_nettype none

module hcgs_core (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_req_valid,
    input  wire hcgs_pkg::t_req          i_req,
    output logic                         o_idle,
    input  wire [hcgs_pkg::CNT_W-1:0]    i_limit,
    output logic                         o_res_valid,
    output hcgs_pkg::t_res               o_res,
    input  wire                          i_res_ready
);
    import hcgs_pkg::*;

    // graph storage
    logic [NODES-1:0]        r_adj   [NODES];
    logic signed [VAL_W-1:0] r_heur  [NODES];
    logic [NODE_W-1:0]       r_par   [NODES];

    // search working state
    logic [NODE_W-1:0]       r_stack [NODES];
    logic [NODE_W-1:0]       r_cb    [NODES];
    logic signed [VAL_W-1:0] r_cbv   [NODES];
    logic [NODES-1:0]        r_open, r_closed, r_row;
    logic [CNT_W-1:0]        r_top, r_m, r_i, r_v, r_cnt;
    logic [NODE_W-1:0]       r_u, r_s, r_t, r_cur;
    logic signed [VAL_W-1:0] r_hv;
    t_res                    r_res;
    t_state                  r_state, n_state;

    logic [NODE_W-1:0] w_vi;
    logic [NODE_W-1:0] w_top1;
    logic [NODE_W-1:0] w_m1;
    logic [NODE_W-1:0] w_i1;
    logic              w_take;
    logic              w_shift;
    logic              w_done;

    assign w_vi    = r_v[NODE_W-1:0];
    assign w_top1  = NODE_W'(r_top - CNT_W'(1));
    assign w_m1    = NODE_W'(r_m - CNT_W'(1));
    assign w_i1    = NODE_W'(r_i - CNT_W'(1));
    assign w_take  = r_row[w_vi] && !(r_open[w_vi] || r_closed[w_vi]);
    assign w_shift = (r_i != '0) && (r_cbv[w_i1] > r_hv);
    assign w_done  = (r_cur == r_s) || (r_cnt == CNT_W'(MAX_OUT - 1));

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and result outputs
    always_comb begin
        n_state     = r_state;
        o_res_valid = 1'b0;
        o_res       = r_res;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid && i_req.cmd == CMD_SEARCH) begin
                    n_state = (i_req.start_node == i_req.target_node) ? S_RES : S_POP;
                end
            end
            S_POP: n_state = S_SCAN;
            S_SCAN: begin
                if (r_v >= i_limit) begin
                    n_state = S_PUSH;
                end else if (w_take) begin
                    n_state = (w_vi == r_t) ? S_PATH : S_INS;
                end
            end
            S_INS: begin
                if (!w_shift) n_state = S_SCAN;
            end
            S_PUSH: begin
                if (!(r_m != '0 && r_top < CNT_W'(NODES))) begin
                    n_state = (r_top == '0) ? S_RES : S_POP;
                end
            end
            S_RES: begin
                o_res_valid = 1'b1;
                if (i_res_ready) n_state = S_IDLE;
            end
            S_PATH: begin
                o_res_valid = 1'b1;
                o_res       = '{status: ST_PATH, path_node: r_cur, last: w_done};
                if (i_res_ready && w_done) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_idle = (r_state == S_IDLE);

    // control counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top <= '0;
            r_m   <= '0;
            r_i   <= '0;
            r_v   <= '0;
            r_cnt <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_top <= CNT_W'(1);
                    r_cnt <= '0;
                end
                S_POP: begin
                    r_top <= r_top - CNT_W'(1);
                    r_v   <= '0;
                    r_m   <= '0;
                end
                S_SCAN: begin
                    if (r_v < i_limit) begin
                        if (w_take) begin
                            r_i <= r_m;
                        end else begin
                            r_v <= r_v + CNT_W'(1);
                        end
                    end
                end
                S_INS: begin
                    if (w_shift) begin
                        r_i <= r_i - CNT_W'(1);
                    end else begin
                        r_m <= r_m + CNT_W'(1);
                        r_v <= r_v + CNT_W'(1);
                    end
                end
                S_PUSH: begin
                    if (r_m != '0 && r_top < CNT_W'(NODES)) begin
                        r_m   <= r_m - CNT_W'(1);
                        r_top <= r_top + CNT_W'(1);
                    end
                end
                S_PATH: begin
                    if (i_res_ready && !w_done) r_cnt <= r_cnt + CNT_W'(1);
                end
                default: ;
            endcase
        end
    end

    // storage and datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    if (i_req.cmd == CMD_LOAD_ROW) r_adj[i_req.node_index] <= i_req.row_bits;
                    if (i_req.cmd == CMD_LOAD_VAL) r_heur[i_req.node_index] <= i_req.node_value;
                    if (i_req.cmd == CMD_SEARCH) begin
                        r_s        <= i_req.start_node;
                        r_t        <= i_req.target_node;
                        r_stack[0] <= i_req.start_node;
                        r_open     <= NODES'(1) << i_req.start_node;
                        r_closed   <= '0;
                        r_res      <= '{status: ST_SAME, path_node: i_req.start_node,
                                        last: 1'b1};
                    end
                end
            end
            S_POP: begin
                r_u      <= r_stack[w_top1];
                r_row    <= r_adj[r_stack[w_top1]];
                r_open   <= r_open & ~(NODES'(1) << r_stack[w_top1]);
                r_closed <= r_closed | (NODES'(1) << r_stack[w_top1]);
            end
            S_SCAN: begin
                if (r_v < i_limit && w_take) begin
                    r_par[w_vi] <= r_u;
                    r_hv        <= r_heur[w_vi];
                    r_cur       <= r_t;
                end
            end
            S_INS: begin
                // one step of the sorted insert
                if (w_shift) begin
                    r_cb[r_i[NODE_W-1:0]]  <= r_cb[w_i1];
                    r_cbv[r_i[NODE_W-1:0]] <= r_cbv[w_i1];
                end else begin
                    r_cb[r_i[NODE_W-1:0]]  <= w_vi;
                    r_cbv[r_i[NODE_W-1:0]] <= r_hv;
                end
            end
            S_PUSH: begin
                if (r_m != '0 && r_top < CNT_W'(NODES)) begin
                    r_stack[r_top[NODE_W-1:0]] <= r_cb[w_m1];
                    r_open <= r_open | (NODES'(1) << r_cb[w_m1]);
                end else if (r_top == '0) begin
                    r_res <= '{status: ST_NOTFOUND, path_node: '0, last: 1'b1};
                end
            end
            S_PATH: begin
                if (i_res_ready && !w_done) r_cur <= r_par[r_cur];
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

>>> design/hill_climbing_graph_search.sv
// ----------------------------------------------------------------------------
// hill_climbing_graph_search
// Hill-climbing search with backtracking over a loaded 16-node graph.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel carries requests: tuser = command (load row, load value,
//   search), tdata = node_index, row_bits, node_value, start, target.
//   Loads give no result. A search runs in a sequencer that pops one node,
//   scans successors one per cycle while no new child is being inserted,
//   moves one position per step in the sorted insert of each new child,
//   and pushes one child per cycle.
//   o_s_tready is low while a search runs or its results are emitted.
//   Master channel gives results: tuser = status, tdata = path node,
//   tlast = final result. A path gives one result per cycle, up to 16.
//   An output register holds each result; a stalled receiver stalls the
//   path walk, and a new request may be taken while the final result waits.
//   The config channel writes num_states; it is ready only while no search
//   runs, so a search always sees one node count from start to end.
//   Synchronous reset idles the sequencer, clears its counters and the output
//   valid, sets num_states to 16 and leaves the graph storage unwritten.
// ----------------------------------------------------------------------------
`default_nettype none

module hill_climbing_graph_search (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [47:0] i_s_tdata,  // node_index, row_bits, node_value, start_node, target_node
    input  wire  [1:0]  i_s_tuser,  // command
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [7:0]  o_m_tdata,  // path_node
    output logic [1:0]  o_m_tuser,  // status
    output logic        o_m_tlast,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [4:0]  i_cfg_data
);
    import hcgs_pkg::*;

    logic [4:0]       r_num;
    logic [CNT_W-1:0] w_limit;
    t_req             w_req;
    logic             w_idle;
    logic             w_res_valid;
    logic             w_res_ready;
    t_res             w_res;
    t_res             r_out;
    logic             r_ovalid;

    // config register, written only between searches
    assign o_cfg_ready = w_idle;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num <= 5'd16;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_num <= i_cfg_data;
        end
    end
    assign w_limit = (r_num > 5'(NODES)) ? CNT_W'(NODES) : CNT_W'(r_num);

    // request decode
    assign w_req = '{cmd:         t_cmd'(i_s_tuser),
                     node_index:  i_s_tdata[3:0],
                     row_bits:    i_s_tdata[19:4],
                     node_value:  i_s_tdata[35:20],
                     start_node:  i_s_tdata[39:36],
                     target_node: i_s_tdata[43:40]};
    assign o_s_tready = w_idle;

    hcgs_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_tvalid),
        .i_req       (w_req),
        .o_idle      (w_idle),
        .i_limit     (w_limit),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_ready (w_res_ready)
    );

    // output register
    assign w_res_ready = !r_ovalid || i_m_tready;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_res_ready) begin
            r_ovalid <= w_res_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) r_out <= w_res;
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {4'b0, r_out.path_node};
    assign o_m_tuser  = r_out.status;
    assign o_m_tlast  = r_out.last;

endmodule

`default_nettype wire

>>> design/hcgs_checker.sv
// ----------------------------------------------------------------------------
// hcgs_checker
// Port-level checks for the graph search block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hcgs_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_s_tvalid,
    input wire       o_s_tready,
    input wire [1:0] i_s_tuser,
    input wire       o_m_tvalid,
    input wire       i_m_tready,
    input wire [1:0] o_m_tuser,
    input wire       o_m_tlast
);
    import hcgs_pkg::*;

    // a held result stays valid
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result dropped while stalled");

    // a search request makes the block busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tuser == CMD_SEARCH |=> !o_s_tready)
        else $error("ready after search request");

    // single-result outcomes always close the search
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser != ST_PATH |-> o_m_tlast)
        else $error("status result without last");

    // nothing is shown right after reset
    a_rst: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind hill_climbing_graph_search hcgs_checker u_hcgs_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

`default_nettype wire
